/* rtl/core/dds_pkg.sv */
// shared types and codes of the discrete distribution sampler
package dds_pkg;

   localparam int UNIFORM_BITS  = 32;
   localparam int REQ_TYPE_BITS = 2;
   localparam int STATUS_BITS   = 2;

   typedef enum logic [REQ_TYPE_BITS-1:0] {
      OP_LOAD   = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_CDF    = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PUT,
      ST_DONE
   } state_type;

endpackage

/* rtl/core/discrete_distribution_sampler.sv */
// top level: request sequencer, table ram and shared compare unit
// load, sample and cdf query scan the table ram one entry per cycle when the table holds
//    entries; clear, a load into an empty table and answers on a full or empty table skip it
// one item at a time: the next request is taken only once the last result has gone into
//    the result register
// reset clears the sequencer, the entry count, the total weight and the result valid flag;
//    table contents are not cleared, only entries below the count are ever read
module discrete_distribution_sampler import dds_pkg::*; #(
   parameter int MAX_ENTRIES = 16,
   parameter int VALUE_BITS  = 32,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                                              clock,
   input  logic                                              reset,
   // request channel
   input  logic                                              req_valid,
   output logic                                              req_ready,
   input  logic [REQ_TYPE_BITS-1:0]                          req_type,
   input  logic signed [VALUE_BITS-1:0]                      req_value,
   input  logic [WEIGHT_BITS-1:0]                            req_weight,
   input  logic [UNIFORM_BITS-1:0]                           req_uniform,
   // result channel
   output logic                                              rsp_valid,
   input  logic                                              rsp_ready,
   output logic [STATUS_BITS-1:0]                            rsp_status,
   output logic signed [VALUE_BITS-1:0]                      rsp_sample_value,
   output logic [$clog2(MAX_ENTRIES)-1:0]                    rsp_sample_index,
   output logic [WEIGHT_BITS+$clog2(MAX_ENTRIES)-1:0]        rsp_cdf_weight,
   output logic [WEIGHT_BITS+$clog2(MAX_ENTRIES)-1:0]        rsp_total_weight,
   output logic [$clog2(MAX_ENTRIES+1)-1:0]                  rsp_entry_count
);

   localparam int IW   = $clog2(MAX_ENTRIES);     // table index
   localparam int CNTW = $clog2(MAX_ENTRIES + 1); // entry count
   localparam int CW   = WEIGHT_BITS + IW;        // cumulative weight
   localparam int PW   = UNIFORM_BITS + CW;       // scaled sample target
   localparam int MW   = VALUE_BITS + CW;         // table word: {value, cum}

   // sequencer state
   state_type                   state_ff, state_in;
   op_type                      op_ff, op_in;
   status_type                  status_ff, status_in;
   logic signed [VALUE_BITS-1:0] key_ff, key_in;
   logic [WEIGHT_BITS-1:0]      wt_ff, wt_in;
   logic [PW-1:0]               target_ff, target_in;
   logic [IW-1:0]               cur_ff, cur_in;
   logic [CNTW-1:0]             held_ff, held_in;
   logic [CW-1:0]               total_ff, total_in;
   logic [CW-1:0]               cdf_ff, cdf_in;
   logic signed [VALUE_BITS-1:0] sel_val_ff, sel_val_in;
   logic [IW-1:0]               sel_idx_ff, sel_idx_in;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   status_type                  rsp_status_ff, rsp_status_in;
   logic signed [VALUE_BITS-1:0] rsp_sval_ff, rsp_sval_in;
   logic [IW-1:0]               rsp_sidx_ff, rsp_sidx_in;
   logic [CW-1:0]               rsp_cdf_ff, rsp_cdf_in;
   logic [CW-1:0]               rsp_total_ff, rsp_total_in;
   logic [CNTW-1:0]             rsp_count_ff, rsp_count_in;

   // table ram ports
   logic                        wr_en;
   logic [IW-1:0]               wr_addr;
   logic [MW-1:0]               wr_data;
   logic [IW-1:0]               rd_addr;
   logic [MW-1:0]               rd_data;

   // shared unit
   logic signed [VALUE_BITS-1:0] ent_value;
   logic [CW-1:0]               ent_cum;
   logic                        val_le;
   logic                        below;
   logic [CW-1:0]               cum_sum;

   logic [CNTW-1:0]             held_m1;
   logic [IW-1:0]               last_idx;
   logic                        rsp_free;

   dds_mem #(
      .DEPTH (MAX_ENTRIES),
      .WIDTH (MW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign ent_value = rd_data[CW +: VALUE_BITS];
   assign ent_cum   = rd_data[CW-1:0];

   dds_unit #(
      .VALUE_BITS  (VALUE_BITS),
      .WEIGHT_BITS (WEIGHT_BITS),
      .CUM_BITS    (CW)
   ) u_unit (
      .ent_value (ent_value),
      .ent_cum   (ent_cum),
      .key       (key_ff),
      .weight    (wt_ff),
      .target    (target_ff),
      .val_le    (val_le),
      .below     (below),
      .cum_sum   (cum_sum)
   );

   // index of the last held entry, valid whenever the table is not empty
   assign held_m1  = held_ff - CNTW'(1);
   assign last_idx = held_m1[IW-1:0];
   // result register can take a new item
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      status_in     = status_ff;
      key_in        = key_ff;
      wt_in         = wt_ff;
      target_in     = target_ff;
      cur_in        = cur_ff;
      held_in       = held_ff;
      total_in      = total_ff;
      cdf_in        = cdf_ff;
      sel_val_in    = sel_val_ff;
      sel_idx_in    = sel_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_sval_in   = rsp_sval_ff;
      rsp_sidx_in   = rsp_sidx_ff;
      rsp_cdf_in    = rsp_cdf_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_addr       = '0;
      req_ready     = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in      = op_type'(req_type);
               key_in     = req_value;
               wt_in      = req_weight;
               // scaled target for the whole sample scan
               target_in  = PW'(req_uniform) * PW'(total_ff);
               status_in  = STAT_OK;
               cdf_in     = '0;
               sel_val_in = '0;
               sel_idx_in = '0;
               case (op_type'(req_type))
                  OP_LOAD: begin
                     if (held_ff == CNTW'(MAX_ENTRIES)) begin
                        status_in = STAT_FULL;
                        state_in  = ST_DONE;
                     end else if (held_ff == '0) begin
                        // empty table: first entry goes straight in
                        wr_en    = 1'b1;
                        wr_addr  = '0;
                        wr_data  = {req_value, CW'(req_weight)};
                        held_in  = held_ff + CNTW'(1);
                        total_in = total_ff + CW'(req_weight);
                        state_in = ST_DONE;
                     end else begin
                        // scan down from the top, shifting larger entries up
                        rd_addr  = last_idx;
                        cur_in   = last_idx;
                        state_in = ST_SCAN;
                     end
                  end
                  OP_SAMPLE: begin
                     if (held_ff == '0) begin
                        status_in = STAT_EMPTY;
                        state_in  = ST_DONE;
                     end else begin
                        rd_addr  = '0;
                        cur_in   = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  OP_CDF: begin
                     if (held_ff == '0) begin
                        state_in = ST_DONE;
                     end else begin
                        rd_addr  = '0;
                        cur_in   = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     // clear: contents stay, count and total drop to zero
                     held_in  = '0;
                     total_in = '0;
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // rd_data holds entry cur_ff this cycle
            case (op_ff)
               OP_LOAD: begin
                  wr_en   = 1'b1;
                  wr_addr = cur_ff + IW'(1);
                  if (val_le) begin
                     // new item lands just above the last entry not greater
                     wr_data  = {key_ff, cum_sum};
                     held_in  = held_ff + CNTW'(1);
                     total_in = total_ff + CW'(wt_ff);
                     state_in = ST_DONE;
                  end else begin
                     wr_data = {ent_value, cum_sum};
                     if (cur_ff == '0) begin
                        state_in = ST_PUT;
                     end else begin
                        rd_addr = cur_ff - IW'(1);
                        cur_in  = cur_ff - IW'(1);
                     end
                  end
               end
               OP_SAMPLE: begin
                  if (cur_ff == last_idx || !below) begin
                     sel_val_in = ent_value;
                     sel_idx_in = cur_ff;
                     state_in   = ST_DONE;
                  end else begin
                     rd_addr = cur_ff + IW'(1);
                     cur_in  = cur_ff + IW'(1);
                  end
               end
               OP_CDF: begin
                  if (val_le) begin
                     cdf_in = ent_cum;
                  end
                  if (!val_le || cur_ff == last_idx) begin
                     state_in = ST_DONE;
                  end else begin
                     rd_addr = cur_ff + IW'(1);
                     cur_in  = cur_ff + IW'(1);
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end

         ST_PUT: begin
            // every held entry was greater: new item becomes entry zero
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = {key_ff, CW'(wt_ff)};
            held_in  = held_ff + CNTW'(1);
            total_in = total_ff + CW'(wt_ff);
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_sval_in   = sel_val_ff;
               rsp_sidx_in   = sel_idx_ff;
               rsp_cdf_in    = cdf_ff;
               rsp_total_in  = total_ff;
               rsp_count_in  = held_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      status_ff     <= status_in;
      key_ff        <= key_in;
      wt_ff         <= wt_in;
      target_ff     <= target_in;
      cur_ff        <= cur_in;
      cdf_ff        <= cdf_in;
      sel_val_ff    <= sel_val_in;
      sel_idx_ff    <= sel_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sval_ff   <= rsp_sval_in;
      rsp_sidx_ff   <= rsp_sidx_in;
      rsp_cdf_ff    <= rsp_cdf_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_sample_value = rsp_sval_ff;
   assign rsp_sample_index = rsp_sidx_ff;
   assign rsp_cdf_weight   = rsp_cdf_ff;
   assign rsp_total_weight = rsp_total_ff;
   assign rsp_entry_count  = rsp_count_ff;

endmodule

/* rtl/core/dds_mem.sv */
// table ram: one write port, one read port with registered read data
module dds_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 52
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/dds_unit.sv */
// shared compare and add unit applied to one table entry per cycle
module dds_unit import dds_pkg::*; #(
   parameter int VALUE_BITS  = 32,
   parameter int WEIGHT_BITS = 16,
   parameter int CUM_BITS    = 20
) (
   input  logic signed [VALUE_BITS-1:0]          ent_value,
   input  logic        [CUM_BITS-1:0]            ent_cum,
   input  logic signed [VALUE_BITS-1:0]          key,
   input  logic        [WEIGHT_BITS-1:0]         weight,
   input  logic        [UNIFORM_BITS+CUM_BITS-1:0] target,
   output logic                                  val_le,
   output logic                                  below,
   output logic        [CUM_BITS-1:0]            cum_sum
);

   // entry value at or below the key
   assign val_le  = (ent_value <= key);
   // cum * 2^32 < uniform * total
   assign below   = ({ent_cum, UNIFORM_BITS'(0)} < target);
   // running weight after an insert below this entry
   assign cum_sum = ent_cum + CUM_BITS'(weight);

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the discrete distribution sampler: directed and random traffic
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import dds_pkg::*;

   localparam int MAX_ENTRIES     = 16;
   localparam int VALUE_BITS      = 32;
   localparam int WEIGHT_BITS     = 16;
   localparam int IDX_BITS        = $clog2(MAX_ENTRIES);
   localparam int CNT_BITS        = $clog2(MAX_ENTRIES + 1);
   localparam int SUM_BITS        = WEIGHT_BITS + IDX_BITS;
   localparam int HALF_PERIOD     = 5;
   localparam int RESET_CYCLES    = 5;
   localparam int WATCHDOG_LIMIT  = 2000;   // cycles with no item moving on either channel
   localparam int DRAIN_CYCLES    = 50;     // a few times the worst load latency
   localparam int ITEMS_PER_PHASE = 80;
   localparam int HOLD_CYCLES     = 300;    // long receiver hold-off, well under the watchdog
   localparam int MAX_SHOWN       = 10;

   // one expected result item, at the block's field widths
   typedef struct packed {
      status_type                   status;
      logic signed [VALUE_BITS-1:0] sample_value;
      logic [IDX_BITS-1:0]          sample_index;
      logic [SUM_BITS-1:0]          cdf_weight;
      logic [SUM_BITS-1:0]          total_weight;
      logic [CNT_BITS-1:0]          entry_count;
   } sampler_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [REQ_TYPE_BITS-1:0]      req_type = OP_CLEAR;
   logic signed [VALUE_BITS-1:0]  req_value = '0;
   logic [WEIGHT_BITS-1:0]        req_weight = '0;
   logic [UNIFORM_BITS-1:0]       req_uniform = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [STATUS_BITS-1:0]        rsp_status;
   logic signed [VALUE_BITS-1:0]  rsp_sample_value;
   logic [IDX_BITS-1:0]           rsp_sample_index;
   logic [SUM_BITS-1:0]           rsp_cdf_weight;
   logic [SUM_BITS-1:0]           rsp_total_weight;
   logic [CNT_BITS-1:0]           rsp_entry_count;

   // shadow copy of the sorted table: values and inclusive running weight sums
   logic signed [VALUE_BITS-1:0]  entry_val [MAX_ENTRIES];
   logic [SUM_BITS-1:0]           entry_cum [MAX_ENTRIES];
   int                            held_entries = 0;

   sampler_result_type            pending_results [$];

   // idling knobs, percent of cycles, and the receiver hold-off left
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_left     = 0;

   // bookkeeping
   int items_sent      = 0;
   int results_checked = 0;
   int mismatch_count  = 0;
   int failures        = 0;
   int quiet_cycles    = 0;
   int op_count [4]    = '{default: 0};
   int full_answers    = 0;
   int empty_answers   = 0;

   always #(HALF_PERIOD) clock = ~clock;

   discrete_distribution_sampler #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .VALUE_BITS  (VALUE_BITS),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_value        (req_value),
      .req_weight       (req_weight),
      .req_uniform      (req_uniform),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_sample_value (rsp_sample_value),
      .rsp_sample_index (rsp_sample_index),
      .rsp_cdf_weight   (rsp_cdf_weight),
      .rsp_total_weight (rsp_total_weight),
      .rsp_entry_count  (rsp_entry_count)
   );

   // true while cum * 2^32 < u * total, i.e. the entry is still short of the target fraction
   function automatic bit cum_short_of_target(logic [SUM_BITS-1:0] cum,
                                               logic [UNIFORM_BITS-1:0] u,
                                               logic [SUM_BITS-1:0] total);
      logic [63:0] lhs;
      logic [63:0] rhs;
      lhs = {12'h000, cum, 32'h0000_0000};
      rhs = 64'(u) * 64'(total);
      return lhs < rhs;
   endfunction

   // update the shadow table with one accepted item and return the result it should produce
   function automatic sampler_result_type apply_request(op_type op,
                                                        logic signed [VALUE_BITS-1:0] value,
                                                        logic [WEIGHT_BITS-1:0] weight,
                                                        logic [UNIFORM_BITS-1:0] uniform);
      sampler_result_type r;
      int pos;
      int i;
      logic [SUM_BITS-1:0] total;
      r = '0;
      case (op)
         OP_LOAD: begin
            if (held_entries >= MAX_ENTRIES) begin
               r.status = STAT_FULL;
            end else begin
               // new entry lands after every entry with a value less than or equal to it
               pos = 0;
               while (pos < held_entries && entry_val[pos] <= value) pos++;
               for (i = held_entries; i > pos; i--) begin
                  entry_val[i] = entry_val[i-1];
                  entry_cum[i] = entry_cum[i-1] + SUM_BITS'(weight);
               end
               entry_val[pos] = value;
               entry_cum[pos] = (pos > 0 ? entry_cum[pos-1] : '0) + SUM_BITS'(weight);
               held_entries++;
            end
         end
         OP_SAMPLE: begin
            if (held_entries == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               total = entry_cum[held_entries-1];
               i = 0;
               while (i + 1 < held_entries && cum_short_of_target(entry_cum[i], uniform, total))
                  i++;
               r.sample_value = entry_val[i];
               r.sample_index = IDX_BITS'(i);
            end
         end
         OP_CDF: begin
            for (i = 0; i < held_entries && entry_val[i] <= value; i++)
               r.cdf_weight = entry_cum[i];
         end
         default: begin
            held_entries = 0;
         end
      endcase
      r.total_weight = held_entries > 0 ? entry_cum[held_entries-1] : '0;
      r.entry_count  = CNT_BITS'(held_entries);
      op_count[op]++;
      if (r.status == STAT_FULL) full_answers++;
      if (r.status == STAT_EMPTY) empty_answers++;
      return r;
   endfunction

   // offer one item, with an optional idle gap in front, and wait for it to be taken
   task automatic send_request(input op_type op, input logic signed [VALUE_BITS-1:0] value,
                               input logic [WEIGHT_BITS-1:0] weight,
                               input logic [UNIFORM_BITS-1:0] uniform);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_type    <= op;
      req_value   <= value;
      req_weight  <= weight;
      req_uniform <= uniform;
      do @(posedge clock); while (req_ready !== 1'b1);
      pending_results.push_back(apply_request(op, value, weight, uniform));
      items_sent++;
   endtask

   // random content biased toward extremes and toward values already in the table
   function automatic logic signed [VALUE_BITS-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return {1'b1, {(VALUE_BITS-1){1'b0}}};
         1: return {1'b0, {(VALUE_BITS-1){1'b1}}};
         2: return VALUE_BITS'((int'($urandom_range(0, 4)) - 2) * 65536);
         3, 4: begin
            if (held_entries > 0)
               return entry_val[$urandom_range(0, held_entries - 1)]
                      + VALUE_BITS'(int'($urandom_range(0, 2)) - 1);
            else
               return $urandom;
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [WEIGHT_BITS-1:0] pick_weight();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return WEIGHT_BITS'($urandom_range(0, 15));
         default: return WEIGHT_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [UNIFORM_BITS-1:0] pick_uniform();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_noise();
      send_request(op_type'($urandom_range(0, 3)), $urandom, WEIGHT_BITS'($urandom), $urandom);
   endtask

   // one well-formed sequence: clear, fill with random pairs, then sample and query
   task automatic run_random_scenario();
      int n_loads;
      int n_queries;
      int k;
      send_request(OP_CLEAR, $urandom, WEIGHT_BITS'($urandom), $urandom);
      // every fourth sequence or so overruns the table to get full-table answers
      n_loads = ($urandom_range(0, 3) == 0) ? MAX_ENTRIES + int'($urandom_range(1, 2))
                                             : int'($urandom_range(1, MAX_ENTRIES));
      for (k = 0; k < n_loads; k++) begin
         if ($urandom_range(0, 9) == 0) send_noise();
         else send_request(OP_LOAD, pick_value(), pick_weight(), $urandom);
      end
      n_queries = $urandom_range(2, 8);
      for (k = 0; k < n_queries; k++) begin
         case ($urandom_range(0, 9))
            0: send_noise();
            1, 2, 3, 4: send_request(OP_CDF, pick_value(), WEIGHT_BITS'($urandom), $urandom);
            default: send_request(OP_SAMPLE, $urandom, WEIGHT_BITS'($urandom), pick_uniform());
         endcase
      end
   endtask

   // sample, query and clear before anything has been loaded
   task automatic test_empty_table();
      send_request(OP_SAMPLE, 32'sd0, 16'd0, 32'h8000_0000);
      send_request(OP_CDF, 32'sh7fff_ffff, 16'd0, 32'd0);
      send_request(OP_CLEAR, 32'sd0, 16'd0, 32'd0);
   endtask

   // extreme values and weights, equal values, cdf at and around stored points, sample extremes
   task automatic test_load_and_query();
      send_request(OP_LOAD, 32'sh8000_0000, 16'd0, 32'd0);
      send_request(OP_LOAD, 32'sh7fff_ffff, 16'hffff, 32'hffff_ffff);
      send_request(OP_LOAD, 32'sd0, 16'd1, 32'd0);
      send_request(OP_LOAD, 32'sd0, 16'd7, 32'd0);     // equal value goes after the first one
      send_request(OP_CDF, 32'sd0, 16'd0, 32'd0);      // counts both equal entries
      send_request(OP_CDF, 32'sh8000_0000, 16'd0, 32'd0);
      send_request(OP_CDF, -32'sd1, 16'd0, 32'd0);
      send_request(OP_CDF, 32'sh7fff_ffff, 16'd0, 32'd0);
      send_request(OP_SAMPLE, 32'sd0, 16'd0, 32'd0);
      send_request(OP_SAMPLE, 32'sd0, 16'd0, 32'hffff_ffff);
      send_request(OP_SAMPLE, 32'sd0, 16'd0, 32'h8000_0000);
      send_request(OP_CLEAR, 32'sd0, 16'd0, 32'd0);
   endtask

   // all weights zero: every entry qualifies, so the first one is picked
   task automatic test_zero_weights();
      send_request(OP_LOAD, 32'sd5, 16'd0, 32'd0);
      send_request(OP_LOAD, -32'sd3, 16'd0, 32'd0);
      send_request(OP_LOAD, 32'sd9, 16'd0, 32'd0);
      send_request(OP_SAMPLE, 32'sd0, 16'd0, 32'h1234_5678);
      send_request(OP_SAMPLE, 32'sd0, 16'd0, 32'hffff_ffff);
      send_request(OP_CLEAR, 32'sd0, 16'd0, 32'd0);
   endtask

   // random sequences under one idling setting
   task automatic test_random_traffic(input int send_pct, input int stall_pct);
      int start_count;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      start_count   = items_sent;
      while (items_sent - start_count < ITEMS_PER_PHASE) run_random_scenario();
   endtask

   // receiver holds off for a long stretch while items keep coming, so the input backs up
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_left     = HOLD_CYCLES;
      run_random_scenario();
      run_random_scenario();
   endtask

   // result side: ready pattern, with the hold-off counted down here
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // compare every accepted result with the oldest expectation
   always @(posedge clock) begin
      sampler_result_type exp_r;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         results_checked++;
         if (pending_results.size() == 0) begin
            failures++;
            $display("unexpected result item at %0t", $realtime);
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_status !== exp_r.status || rsp_sample_value !== exp_r.sample_value ||
                rsp_sample_index !== exp_r.sample_index ||
                rsp_cdf_weight !== exp_r.cdf_weight ||
                rsp_total_weight !== exp_r.total_weight ||
                rsp_entry_count !== exp_r.entry_count) begin
               mismatch_count++;
               if (mismatch_count <= MAX_SHOWN) begin
                  $display("mismatch at %0t: expected st=%0d val=%h idx=%0d cdf=%0d tot=%0d cnt=%0d",
                           $realtime, exp_r.status, exp_r.sample_value, exp_r.sample_index,
                           exp_r.cdf_weight, exp_r.total_weight, exp_r.entry_count);
                  $display("   got st=%0d val=%h idx=%0d cdf=%0d tot=%0d cnt=%0d",
                           rsp_status, rsp_sample_value, rsp_sample_index,
                           rsp_cdf_weight, rsp_total_weight, rsp_entry_count);
               end
            end
         end
      end
   end

   // watchdog: too long with nothing accepted on either side ends the run
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_ready === 1'b1) ||
             (rsp_valid === 1'b1 && rsp_ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed part, no idling
      test_empty_table();
      test_load_and_query();
      test_zero_weights();

      // random part over the idling phases
      test_random_traffic(0, 0);
      test_random_traffic(87, 0);
      test_random_traffic(0, 87);
      test_random_traffic(29, 29);
      test_backpressure();

      // let the last results drain, then a few extra cycles for stray items
      req_valid <= 1'b0;
      while (pending_results.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) failures++;

      $display("covered %0d items: %0d loads, %0d samples, %0d cdf queries, %0d clears",
               items_sent, op_count[OP_LOAD], op_count[OP_SAMPLE], op_count[OP_CDF],
               op_count[OP_CLEAR]);
      $display("%0d results checked, %0d full-table and %0d empty-table answers, %0d mismatches",
               results_checked, full_answers, empty_answers, mismatch_count);
      if (failures == 0 && mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
